>>> sv/u8sd_pkg.sv
// u8sd_pkg: shared types, constants and the sequence decode function
// for the utf8 stream decoder; no dependencies
`default_nettype none

package u8sd_pkg;

   // sequence length codes held in the front end
   localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN_2    = 3'd2;
   localparam logic [2:0] SEQ_LEN_3    = 3'd3;
   localparam logic [2:0] SEQ_LEN_4    = 3'd4;

   localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [20:0] MIN_CP_2       = 21'h000080;
   localparam logic [20:0] MIN_CP_3       = 21'h000800;
   localparam logic [20:0] MIN_CP_4       = 21'h010000;
   localparam logic [20:0] MAX_CP         = 21'h10FFFF;
   localparam logic [20:0] SURR_LOW       = 21'h00D800;
   localparam logic [20:0] SURR_HIGH      = 21'h00DFFF;

   // work handed from front end to back end: a run of replacements,
   // then optionally one code point
   typedef struct packed {
      logic [1:0]  rep_count;
      logic        has_cp;
      logic [20:0] cp;
   } job_type;

   // assemble a complete sequence and apply the overlong/surrogate/range rules
   function automatic logic [20:0] decode_seq(
      input logic [7:0] b0,
      input logic [7:0] b1,
      input logic [7:0] b2,
      input logic [7:0] last_byte,
      input logic [2:0] seq_len
   );
      logic [20:0] c;
      case (seq_len)
         SEQ_LEN_2: begin
            c = {10'd0, b0[4:0], last_byte[5:0]};
            if (c < MIN_CP_2) c = REPLACEMENT_CP;
         end
         SEQ_LEN_3: begin
            c = {5'd0, b0[3:0], b1[5:0], last_byte[5:0]};
            if (c < MIN_CP_3 || (c >= SURR_LOW && c <= SURR_HIGH)) c = REPLACEMENT_CP;
         end
         default: begin
            c = {b0[2:0], b1[5:0], b2[5:0], last_byte[5:0]};
            if (c < MIN_CP_4 || c > MAX_CP) c = REPLACEMENT_CP;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> sv/u8sd_front.sv
// u8sd_front: accepts bytes, tracks the pending sequence and builds jobs
// depends on u8sd_pkg
`default_nettype none

module u8sd_front
   import u8sd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   input  wire logic [7:0] req_data_byte,
   output logic            req_full,
   input  wire logic       job_full,
   output logic            job_push,
   output job_type         job
);

   logic [7:0] pend_ff [3];
   logic [1:0] cnt_ff, cnt_in;
   logic [2:0] len_ff, len_in;
   logic       accept;
   logic       store_en;
   logic [1:0] store_idx;
   logic       is_cont;
   logic       fresh_has;
   logic [20:0] fresh_cp;
   logic [2:0] fresh_len;
   logic       job_valid;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign is_cont  = (req_data_byte[7:6] == 2'b10);

   // classify the byte as if nothing were pending
   always_comb begin
      fresh_has = 1'b0;
      fresh_cp  = REPLACEMENT_CP;
      fresh_len = SEQ_LEN_NONE;
      if (req_data_byte == 8'h00) begin
         fresh_has = 1'b0;
      end else if (req_data_byte[7] == 1'b0) begin
         fresh_has = 1'b1;
         fresh_cp  = {13'd0, req_data_byte};
      end else if (req_data_byte[7:5] == 3'b110) begin
         fresh_len = SEQ_LEN_2;
      end else if (req_data_byte[7:4] == 4'b1110) begin
         fresh_len = SEQ_LEN_3;
      end else if (req_data_byte[7:3] == 5'b11110) begin
         fresh_len = SEQ_LEN_4;
      end else begin
         fresh_has = 1'b1;
      end
   end

   // pending sequence update and job build
   always_comb begin
      cnt_in        = cnt_ff;
      len_in        = len_ff;
      store_en      = 1'b0;
      store_idx     = cnt_ff;
      job.rep_count = 2'd0;
      job.has_cp    = 1'b0;
      job.cp        = REPLACEMENT_CP;
      if (cnt_ff != 2'd0 && is_cont) begin
         if (({1'b0, cnt_ff} + 3'd1) == len_ff) begin
            job.has_cp = 1'b1;
            job.cp     = decode_seq(pend_ff[0], pend_ff[1], pend_ff[2],
                                    req_data_byte, len_ff);
            cnt_in     = 2'd0;
            len_in     = SEQ_LEN_NONE;
         end else begin
            store_en = 1'b1;
            cnt_in   = cnt_ff + 2'd1;
         end
      end else begin
         // broken sequence flushes every buffered byte, then fresh handling
         job.rep_count = cnt_ff;
         job.has_cp    = fresh_has;
         job.cp        = fresh_cp;
         if (fresh_len != SEQ_LEN_NONE) begin
            store_en  = 1'b1;
            store_idx = 2'd0;
            cnt_in    = 2'd1;
            len_in    = fresh_len;
         end else begin
            cnt_in = 2'd0;
            len_in = SEQ_LEN_NONE;
         end
      end
      job_valid = (job.rep_count != 2'd0) || job.has_cp;
   end

   assign job_push = accept && job_valid;

   // pending byte buffer
   always_ff @(posedge clock) begin
      if (accept && store_en) pend_ff[store_idx] <= req_data_byte;
   end

   // pending count and length
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         len_ff <= SEQ_LEN_NONE;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         len_ff <= len_in;
      end
   end

   // pending count always short of the expected length
   a_cnt_below_len: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> ({1'b0, cnt_ff} < len_ff))
      else $error("pending count not below expected length");

   // nothing pending means no length
   a_idle_no_len: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> (len_ff == SEQ_LEN_NONE))
      else $error("length set with nothing pending");

endmodule

`default_nettype wire

>>> sv/u8sd_queue.sv
// u8sd_queue: short job queue between front and back end
// depends on u8sd_pkg
`default_nettype none

module u8sd_queue
   import u8sd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ff, wr_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (cnt_ff == FULL_CNT);
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ff];

   // pointer and count next values
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == LAST_IDX) ? '0 : wr_ff + IDX_W'(1);
      if (do_pop)  rd_in = (rd_ff == LAST_IDX) ? '0 : rd_ff + IDX_W'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CNT_W'(1);
      if (do_pop && !do_push) cnt_in = cnt_ff - CNT_W'(1);
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_job;
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // a push with no pop leaves something to read
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !pop) |=> !empty)
      else $error("queue empty after push");

endmodule

`default_nettype wire

>>> sv/u8sd_back.sv
// u8sd_back: expands each job into result transactions, one per cycle while rsp_pop is high
// depends on u8sd_pkg
`default_nettype none

module u8sd_back
   import u8sd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type job,
   input  wire logic    job_empty,
   output logic         job_pop,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output logic [20:0]  rsp_code_point,
   output logic         rsp_last_of_run
);

   logic        busy_ff, busy_in;
   logic [1:0]  rep_ff, rep_in;
   logic        has_ff, has_in;
   logic [20:0] cp_ff, cp_in;
   logic        take;
   logic        done;

   assign rsp_empty       = !busy_ff;
   assign rsp_code_point  = (rep_ff != 2'd0) ? REPLACEMENT_CP : cp_ff;
   assign rsp_last_of_run = (rep_ff == 2'd0) || (rep_ff == 2'd1 && !has_ff);

   assign take    = busy_ff && rsp_pop;
   assign done    = !busy_ff || (take && rsp_last_of_run);
   assign job_pop = done && !job_empty;

   // current job: step through replacements, reload when finished
   always_comb begin
      busy_in = busy_ff;
      rep_in  = rep_ff;
      has_in  = has_ff;
      cp_in   = cp_ff;
      if (done) begin
         busy_in = !job_empty;
         rep_in  = job.rep_count;
         has_in  = job.has_cp;
         cp_in   = job.cp;
      end else if (take) begin
         rep_in = rep_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      has_ff <= has_in;
      cp_ff  <= cp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rep_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         rep_ff  <= rep_in;
      end
   end

   // a held job always has something left to send
   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rep_ff != 2'd0 || has_ff))
      else $error("back end holds a job with no results");

endmodule

`default_nettype wire

>>> sv/utf8_stream_decoder.sv
// utf8_stream_decoder: byte stream to code point decoder with U+FFFD replacement
// depends on u8sd_pkg, u8sd_front, u8sd_queue, u8sd_back
//
// Usage:
//   Input queue side: drive req_data_byte and raise req_push; the byte is
//   taken at a clock edge where req_push is high and req_full is low. A zero
//   byte ends a string and flushes pending bytes as U+FFFD.
//   Result queue side: while rsp_empty is low, rsp_code_point and
//   rsp_last_of_run show the oldest result; it is taken at an edge where
//   rsp_pop is high. rsp_last_of_run marks the final result of one byte.
// Timing:
//   A byte's job goes to the job queue, then to the back-end result register.
//   One byte per cycle is accepted while rsp_pop is high and each byte gives
//   at most one result. A byte with more results holds the back end until all
//   are popped; the job queue (QUEUE_DEPTH entries) absorbs that and req_full
//   rises when full. Bytes that only extend a pending sequence give no result.
// Reset: synchronous; clears pending state, the job queue and the result
//   register. When the receiver stops popping, the queue fills and req_full
//   holds the sender off; nothing is dropped.
`default_nettype none

module utf8_stream_decoder
   import u8sd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_data_byte,
   output logic             req_full,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [20:0]      rsp_code_point,
   output logic             rsp_last_of_run
);

   job_type front_job;
   job_type queue_job;
   logic    job_push;
   logic    job_full;
   logic    job_pop;
   logic    job_empty;

   // byte classification and pending sequence
   u8sd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_full      (req_full),
      .job_full      (job_full),
      .job_push      (job_push),
      .job           (front_job)
   );

   // decoupling queue
   u8sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .full     (job_full),
      .pop      (job_pop),
      .pop_job  (queue_job),
      .empty    (job_empty)
   );

   // result expansion
   u8sd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job             (queue_job),
      .job_empty       (job_empty),
      .job_pop         (job_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

>>> verif/testbench.sv
// testbench for utf8_stream_decoder: random and directed utf-8 byte streams
// checked against a scoreboard that decodes the accepted bytes in order
// depends on u8sd_pkg and the utf8_stream_decoder rtl
module testbench
   import u8sd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 353;
   localparam int QUIET_BYTES  = 50;

   // decoder state tracker and queue of expected code points
   class decode_tracker;
      typedef struct {
         logic [20:0] cp;
         logic        last;
      } cp_item;

      cp_item      expected_cps[$];
      logic [7:0]  held[3];
      logic [1:0]  held_count = 2'd0;
      logic [2:0]  seq_len = SEQ_LEN_NONE;
      int          mismatches = 0;

      // byte seen with nothing pending
      function void start_fresh(logic [7:0] b, ref logic [20:0] run[$]);
         if (b == 8'h00) return;
         if (b[7] == 1'b0) begin
            run.push_back({13'd0, b});
            return;
         end
         if (b[7:5] == 3'b110) seq_len = SEQ_LEN_2;
         else if (b[7:4] == 4'b1110) seq_len = SEQ_LEN_3;
         else if (b[7:3] == 5'b11110) seq_len = SEQ_LEN_4;
         else begin
            run.push_back(REPLACEMENT_CP);
            return;
         end
         held[0] = b;
         held_count = 2'd1;
      endfunction

      // value of the held sequence closed by its final continuation byte
      function logic [20:0] close_seq(logic [7:0] b);
         logic [20:0] value;
         case (seq_len)
            SEQ_LEN_2: begin
               value = {10'd0, held[0][4:0], b[5:0]};
               if (value < MIN_CP_2) value = REPLACEMENT_CP;
            end
            SEQ_LEN_3: begin
               value = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
               if (value < MIN_CP_3) value = REPLACEMENT_CP;
               if (value >= SURR_LOW && value <= SURR_HIGH) value = REPLACEMENT_CP;
            end
            default: begin
               value = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
               if (value < MIN_CP_4 || value > MAX_CP) value = REPLACEMENT_CP;
            end
         endcase
         return value;
      endfunction

      // one accepted input transaction
      function void note_byte(logic [7:0] b);
         logic [20:0] run[$];
         if (seq_len != SEQ_LEN_NONE) begin
            if (b[7:6] == 2'b10) begin
               if (held_count + 1 == seq_len) begin
                  run.push_back(close_seq(b));
                  held_count = 2'd0;
                  seq_len = SEQ_LEN_NONE;
               end else begin
                  held[held_count] = b;
                  held_count = held_count + 2'd1;
               end
            end else begin
               // broken sequence: lead and each held continuation become U+FFFD
               repeat (held_count) run.push_back(REPLACEMENT_CP);
               held_count = 2'd0;
               seq_len = SEQ_LEN_NONE;
               start_fresh(b, run);
            end
         end else begin
            start_fresh(b, run);
         end
         foreach (run[i]) expected_cps.push_back('{cp: run[i], last: (i == run.size() - 1)});
      endfunction

      // one accepted result transaction
      function void check_result(logic [20:0] cp, logic last);
         cp_item want;
         if (expected_cps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: result cp=%h last=%b with nothing expected", cp, last);
            return;
         end
         want = expected_cps.pop_front();
         if (cp !== want.cp || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: code_point exp %h got %h, last_of_run exp %b got %b",
                        want.cp, cp, want.last, last);
         end
      endfunction

      function int outstanding();
         return expected_cps.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [20:0] rsp_code_point;
   logic        rsp_last_of_run;

   decode_tracker tracker = new();
   bit            quiet_tail = 1'b0;
   int            bytes_sent = 0;

   utf8_stream_decoder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_data_byte   (req_data_byte),
      .req_full        (req_full),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_code_point  (rsp_code_point),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // push one byte, with an optional idle burst ahead of it
   task automatic send_byte(input logic [7:0] b);
      bit accepted;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data_byte <= b;
      do begin
         @(negedge clock);
         accepted = !req_full;
         @(posedge clock);
      end while (!accepted);
      tracker.note_byte(b);
      bytes_sent++;
   endtask

   // one random chunk: mostly well-formed sequences with random content
   task automatic send_chunk();
      int         kind;
      int         conts;
      logic [7:0] lead;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         send_byte(8'($urandom_range(8'h01, 8'h7F)));
      end else if (kind < 85) begin
         if (kind < 50) begin
            lead = 8'($urandom_range(8'hC0, 8'hDF));
            conts = 1;
         end else if (kind < 70) begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            conts = 2;
         end else begin
            lead = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(8'hF0, 8'hF7)
                                                  : $urandom_range(8'hF0, 8'hF4));
            conts = 3;
         end
         send_byte(lead);
         repeat (conts) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 90) begin
         send_byte(8'h00);
      end else if (kind < 95) begin
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         // three- or four-byte lead with up to two continuations; a truncated one is broken by whatever comes next
         send_byte(8'($urandom_range(8'hE0, 8'hF7)));
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end
   endtask

   // result side: pop with random stall bursts
   initial begin
      forever begin
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
      end
   end

   // result monitor, sampled mid-cycle
   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            tracker.check_result(rsp_code_point, rsp_last_of_run);
      end
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // main stimulus
   initial begin
      logic [7:0] directed_bytes[$];
      int         total;
      bit         paused_once;
      directed_bytes = '{
         8'h41, 8'h7F, 8'h00,                 // ascii and end of string alone
         8'hC0, 8'h80,                        // overlong two-byte lead
         8'hDF, 8'hBF,                        // largest two-byte value
         8'hED, 8'hA0, 8'h80,                 // surrogate
         8'hF4, 8'h8F, 8'hBF, 8'hBF,          // largest scalar value
         8'hF4, 8'h90, 8'h80, 8'h80,          // above the unicode range
         8'h80, 8'hFF,                        // bytes that cannot start a sequence
         8'hF0, 8'h9F, 8'h98, 8'h41,          // broken four-byte sequence
         8'hE2, 8'h82, 8'h00                  // end of string flushes pending bytes
      };
      paused_once = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      total = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < total) begin
         if (bytes_sent >= total - QUIET_BYTES) quiet_tail = 1'b1;
         if (!paused_once && bytes_sent >= total / 2) begin
            // hold off until the result queue has drained completely
            paused_once = 1'b1;
            req_push <= 1'b0;
            @(posedge clock);
            while (tracker.outstanding() != 0) @(posedge clock);
         end
         send_chunk();
      end
      req_push <= 1'b0;

      // drain, then wait for stray results
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
